### rtl/iee_pkg.sv
// Shared types, codes and helper functions of the infix expression evaluator.
`default_nettype none

package iee_pkg;

    localparam logic [47:0] QMAX    = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] QMIN    = 48'h8000_0000_0000;
    localparam int          ERR_INT = 1111;

    localparam logic [7:0] CHR_0     = 8'h30;
    localparam logic [7:0] CHR_9     = 8'h39;
    localparam logic [7:0] CHR_POINT = 8'h2E;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_MINUS = 8'h2D;
    localparam logic [7:0] CHR_STAR  = 8'h2A;
    localparam logic [7:0] CHR_SLASH = 8'h2F;
    localparam logic [7:0] CHR_OPEN  = 8'h28;
    localparam logic [7:0] CHR_CLOSE = 8'h29;
    localparam logic [7:0] CHR_EQ    = 8'h3D;

    typedef enum logic [2:0] {
        OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_PAR
    } t_op;

    typedef enum logic [3:0] {
        CH_DIGIT, CH_POINT, CH_PLUS, CH_MINUS, CH_MUL, CH_DIV,
        CH_OPEN, CH_CLOSE, CH_EQ, CH_OTHER
    } t_class;

    typedef enum logic [1:0] {
        PP_NONE, PP_OPEN, PP_NEG
    } t_paren;

    typedef enum logic [1:0] {
        PH_NONE, PH_INT, PH_FRAC, PH_TAIL
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK, ST_DIV_ZERO, ST_OVERFLOW, ST_UNDERFLOW
    } t_status;

    typedef enum logic [2:0] {
        ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_LIT
    } t_alu_op;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_LIT_CHAR, CMD_LIT_GO, CMD_PUSH_LIT, CMD_OP_PUSH,
        CMD_OP_PUSH_PAR, CMD_OP_POP, CMD_OP_DROP, CMD_POP_B, CMD_POP_A,
        CMD_DIV_ZERO, CMD_ALU_GO, CMD_PUSH_RES, CMD_RES_POP, CMD_EMIT
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_MAIN, S_LIT_GO, S_LIT_WAIT, S_LIT_PUSH, S_SETTLE,
        S_CHECK, S_POP_OP, S_POP_B, S_POP_WAIT, S_POP_A, S_ALU_GO, S_ALU_WAIT,
        S_PUSH_RES, S_EMIT
    } t_state;

    typedef struct packed {
        t_cmd cmd;
        logic neg;
    } t_dp_cmd;

    typedef struct packed {
        t_class cls;
        logic   lit_active;
        logic   op_empty;
        t_op    op_top;
        t_op    opcode;
        logic   b_zero;
        logic   alu_done;
        logic   out_free;
    } t_dp_stat;

    function automatic t_class classify(input logic [7:0] c);
        t_class k;
        priority if (c >= CHR_0 && c <= CHR_9) k = CH_DIGIT;
        else if (c == CHR_POINT) k = CH_POINT;
        else if (c == CHR_PLUS)  k = CH_PLUS;
        else if (c == CHR_MINUS) k = CH_MINUS;
        else if (c == CHR_STAR)  k = CH_MUL;
        else if (c == CHR_SLASH) k = CH_DIV;
        else if (c == CHR_OPEN)  k = CH_OPEN;
        else if (c == CHR_CLOSE) k = CH_CLOSE;
        else if (c == CHR_EQ)    k = CH_EQ;
        else k = CH_OTHER;
        return k;
    endfunction

    function automatic logic [47:0] pow10(input logic [2:0] fd);
        logic [47:0] p;
        unique case (fd)
            3'd0:    p = 48'd1;
            3'd1:    p = 48'd10;
            3'd2:    p = 48'd100;
            3'd3:    p = 48'd1000;
            3'd4:    p = 48'd10000;
            default: p = 48'd100000;
        endcase
        return p;
    endfunction

    function automatic logic [47:0] mag(input logic signed [47:0] x);
        return x[47] ? 48'(-x) : 48'(x);
    endfunction

endpackage

`default_nettype wire

### rtl/infix_expression_evaluator.sv
// Top level of the infix expression evaluator: controller and datapath.
//
//   channel   direction  beat contents
//   s_*       in         tdata[7:0] character
//   m_*       out        tdata[47:0] result_value, tuser[1:0] status
//
// A character that only feeds a literal or is ignored passes through decode and back to idle.
// Applying an operator pops it and both operands, runs the arithmetic unit and pushes the
// result; closing a literal runs the divider once more.
// The serial multiplier and restoring divider in the arithmetic unit set the rate.
// Reset is synchronous, active low, and clears both stacks by their counts.
// A waiting result beat does not block input; only the next '=' waits for it.
`default_nettype none

module infix_expression_evaluator #(
    parameter int STACK_DEPTH   = 64,
    parameter int FRACTION_BITS = 16
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    input  wire [7:0]   i_s_tdata,   // [7:0] character
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    output logic [47:0] o_m_tdata,   // [47:0] result_value
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    iee_pkg::t_dp_cmd  dp_cmd;
    iee_pkg::t_dp_stat dp_stat;

    iee_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    iee_dp #(
        .STACK_DEPTH   (STACK_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

`default_nettype wire

### rtl/iee_alu.sv
// Arithmetic unit: saturating add/subtract, bit-serial multiply and restoring divide.
`default_nettype none

module iee_alu #(
    parameter int FRACTION_BITS = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  iee_pkg::t_alu_op     i_op,
    input  wire logic signed [47:0] i_a,
    input  wire logic signed [47:0] i_b,
    output logic                 o_done,
    output logic signed [47:0]   o_res
);

    localparam int DW = 48 + FRACTION_BITS;
    localparam int NW = $clog2(DW + 1);

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    iee_pkg::t_alu_op    r_op, n_op;
    logic                r_neg, n_neg;
    logic                r_sat, n_sat;
    logic [NW-1:0]       r_cnt, n_cnt;
    logic [47:0]         r_y, n_y;
    logic [47:0]         r_hi, n_hi;
    logic [DW-1:0]       r_lo, n_lo;
    logic signed [47:0]  r_res, n_res;

    logic [48:0]         sum_as;
    logic [48:0]         mul_sum;
    logic [48:0]         rem_sh;
    logic                rem_ge;
    logic [95:0]         prod;
    logic                fin_ovf;
    logic [47:0]         fin_m;

    always_comb begin
        sum_as  = (i_op == iee_pkg::ALU_SUB) ? ({i_a[47], i_a} - {i_b[47], i_b})
                                             : ({i_a[47], i_a} + {i_b[47], i_b});
        mul_sum = {1'b0, r_hi[47:0]} + (r_lo[0] ? {1'b0, r_y} : 49'd0);
        rem_sh  = {r_hi[47:0], r_lo[DW-1]};
        rem_ge  = rem_sh >= {1'b0, r_y};
        prod    = {r_hi[47:0], r_lo[47:0]};
        if (r_op == iee_pkg::ALU_MUL) begin
            fin_ovf = |(prod >> (47 + FRACTION_BITS));
            fin_m   = 48'(prod >> FRACTION_BITS);
        end else begin
            fin_ovf = |(r_lo >> 47);
            fin_m   = r_lo[47:0];
        end

        n_busy = r_busy;
        n_done = 1'b0;
        n_op   = r_op;
        n_neg  = r_neg;
        n_sat  = r_sat;
        n_cnt  = r_cnt;
        n_y    = r_y;
        n_hi   = r_hi;
        n_lo   = r_lo;
        n_res  = r_res;

        if (i_start) begin
            n_op  = i_op;
            n_hi  = '0;
            n_sat = 1'b0;
            n_neg = i_a[47] ^ i_b[47];
            n_y   = iee_pkg::mag(i_b);
            unique case (i_op)
                iee_pkg::ALU_ADD, iee_pkg::ALU_SUB: begin
                    if (sum_as[48] != sum_as[47]) begin
                        n_res = sum_as[48] ? iee_pkg::QMIN : iee_pkg::QMAX;
                    end else begin
                        n_res = sum_as[47:0];
                    end
                    n_done = 1'b1;
                end
                iee_pkg::ALU_MUL: begin
                    n_lo   = DW'(iee_pkg::mag(i_a));
                    n_cnt  = NW'(48);
                    n_busy = 1'b1;
                end
                iee_pkg::ALU_DIV: begin
                    n_lo   = DW'(iee_pkg::mag(i_a)) << FRACTION_BITS;
                    n_cnt  = NW'(DW);
                    n_busy = 1'b1;
                end
                default: begin
                    n_neg  = 1'b0;
                    n_y    = i_b;
                    n_sat  = i_a >= iee_pkg::QMAX;
                    n_lo   = DW'(i_a) << FRACTION_BITS;
                    n_cnt  = NW'(DW);
                    n_busy = 1'b1;
                end
            endcase
        end else if (r_busy) begin
            if (r_cnt != '0) begin
                n_cnt = r_cnt - NW'(1);
                if (r_op == iee_pkg::ALU_MUL) begin
                    n_hi = mul_sum[48:1];
                    n_lo = DW'({mul_sum[0], r_lo[47:1]});
                end else begin
                    n_hi = rem_ge ? 48'(rem_sh - {1'b0, r_y}) : rem_sh[47:0];
                    n_lo = {r_lo[DW-2:0], rem_ge};
                end
            end else begin
                n_busy = 1'b0;
                n_done = 1'b1;
                if (r_sat) begin
                    n_res = iee_pkg::QMAX;
                end else if (fin_ovf) begin
                    n_res = r_neg ? iee_pkg::QMIN : iee_pkg::QMAX;
                end else begin
                    n_res = r_neg ? -$signed(fin_m) : $signed(fin_m);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op  <= n_op;
        r_neg <= n_neg;
        r_sat <= n_sat;
        r_cnt <= n_cnt;
        r_y   <= n_y;
        r_hi  <= n_hi;
        r_lo  <= n_lo;
        r_res <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

`default_nettype wire

### rtl/iee_dp.sv
// Datapath: character register, literal builder, arithmetic unit, number and operator stacks, result register.
`default_nettype none

module iee_dp #(
    parameter int STACK_DEPTH   = 64,
    parameter int FRACTION_BITS = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  iee_pkg::t_dp_cmd    i_cmd,
    output iee_pkg::t_dp_stat   o_stat,
    input  wire logic [7:0]     i_s_tdata,
    output logic                o_m_tvalid,
    input  wire                 i_m_tready,
    output logic [47:0]         o_m_tdata,
    output logic [1:0]          o_m_tuser
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [47:0] ERR_VAL = 48'(iee_pkg::ERR_INT) << FRACTION_BITS;

    logic [7:0]          r_char, n_char;
    logic [47:0]         r_lit, n_lit;
    logic [2:0]          r_fd, n_fd;
    iee_pkg::t_phase     r_phase, n_phase;
    iee_pkg::t_status    r_err, n_err;
    logic [CW-1:0]       r_ncnt, n_ncnt;
    logic [CW-1:0]       r_opcnt, n_opcnt;
    logic signed [47:0]  r_a, n_a;
    logic signed [47:0]  r_b, n_b;
    iee_pkg::t_op        r_opcode, n_opcode;
    logic                r_out_valid, n_out_valid;
    logic [47:0]         r_out_data, n_out_data;
    iee_pkg::t_status    r_out_stat, n_out_stat;

    logic signed [47:0]  num_mem [STACK_DEPTH];
    iee_pkg::t_op        op_mem [STACK_DEPTH];
    logic signed [47:0]  r_num_rd;
    iee_pkg::t_op        r_op_rd;
    logic [AW-1:0]       num_raddr, op_raddr;
    logic                num_we, op_we;
    logic signed [47:0]  num_wdata;
    iee_pkg::t_op        op_wdata;

    iee_pkg::t_class     cls;
    logic [51:0]         lit10;
    logic [47:0]         add_val;
    logic                do_push;
    logic                out_free;

    logic                alu_start;
    iee_pkg::t_alu_op    alu_op;
    logic signed [47:0]  alu_a, alu_b;
    logic                alu_done;
    logic signed [47:0]  alu_res;

    function automatic iee_pkg::t_status flag(input iee_pkg::t_status cur,
                                               input iee_pkg::t_status code);
        return (cur == iee_pkg::ST_OK) ? code : cur;
    endfunction

    iee_alu #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (alu_start),
        .i_op    (alu_op),
        .i_a     (alu_a),
        .i_b     (alu_b),
        .o_done  (alu_done),
        .o_res   (alu_res)
    );

    assign cls       = iee_pkg::classify(r_char);
    assign num_raddr = AW'(r_ncnt - CW'(1));
    assign op_raddr  = AW'(r_opcnt - CW'(1));
    assign out_free  = !r_out_valid || i_m_tready;
    assign lit10     = ({4'd0, r_lit} << 3) + ({4'd0, r_lit} << 1) + 52'(r_char[3:0]);
    assign add_val   = (r_lit >= iee_pkg::QMAX || lit10 > 52'(iee_pkg::QMAX))
                       ? iee_pkg::QMAX : lit10[47:0];

    always_comb begin
        n_char      = r_char;
        n_lit       = r_lit;
        n_fd        = r_fd;
        n_phase     = r_phase;
        n_err       = r_err;
        n_ncnt      = r_ncnt;
        n_opcnt     = r_opcnt;
        n_a         = r_a;
        n_b         = r_b;
        n_opcode    = r_opcode;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_stat  = r_out_stat;
        num_we      = 1'b0;
        op_we       = 1'b0;
        num_wdata   = i_cmd.neg ? -alu_res : alu_res;
        op_wdata    = iee_pkg::OP_PAR;
        do_push     = 1'b0;
        alu_start   = 1'b0;
        alu_op      = iee_pkg::ALU_ADD;
        alu_a       = r_a;
        alu_b       = r_b;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (i_cmd.cmd)
            iee_pkg::CMD_NONE: begin
            end
            iee_pkg::CMD_LOAD: begin
                n_char = i_s_tdata;
            end
            iee_pkg::CMD_LIT_CHAR: begin
                if (cls == iee_pkg::CH_DIGIT) begin
                    if (r_phase == iee_pkg::PH_NONE || r_phase == iee_pkg::PH_INT) begin
                        n_phase = iee_pkg::PH_INT;
                        n_lit   = add_val;
                    end else if (r_phase == iee_pkg::PH_FRAC && r_fd < 3'd5) begin
                        n_lit = add_val;
                        n_fd  = r_fd + 3'd1;
                    end
                end else begin
                    n_phase = (r_phase == iee_pkg::PH_NONE || r_phase == iee_pkg::PH_INT)
                              ? iee_pkg::PH_FRAC : iee_pkg::PH_TAIL;
                end
            end
            iee_pkg::CMD_LIT_GO: begin
                alu_start = 1'b1;
                alu_op    = iee_pkg::ALU_LIT;
                alu_a     = r_lit;
                alu_b     = iee_pkg::pow10(r_fd);
            end
            iee_pkg::CMD_PUSH_LIT: begin
                do_push = 1'b1;
                n_lit   = '0;
                n_fd    = '0;
                n_phase = iee_pkg::PH_NONE;
            end
            iee_pkg::CMD_PUSH_RES: begin
                do_push = 1'b1;
            end
            iee_pkg::CMD_OP_PUSH, iee_pkg::CMD_OP_PUSH_PAR: begin
                if (i_cmd.cmd == iee_pkg::CMD_OP_PUSH_PAR) begin
                    op_wdata = iee_pkg::OP_PAR;
                end else begin
                    unique case (cls)
                        iee_pkg::CH_PLUS:  op_wdata = iee_pkg::OP_ADD;
                        iee_pkg::CH_MINUS: op_wdata = iee_pkg::OP_SUB;
                        iee_pkg::CH_MUL:   op_wdata = iee_pkg::OP_MUL;
                        default:           op_wdata = iee_pkg::OP_DIV;
                    endcase
                end
                if (r_opcnt >= CW'(STACK_DEPTH)) begin
                    n_err = flag(r_err, iee_pkg::ST_OVERFLOW);
                end else begin
                    op_we   = 1'b1;
                    n_opcnt = r_opcnt + CW'(1);
                end
            end
            iee_pkg::CMD_OP_POP: begin
                n_opcode = r_op_rd;
                n_opcnt  = r_opcnt - CW'(1);
            end
            iee_pkg::CMD_OP_DROP: begin
                n_opcnt = r_opcnt - CW'(1);
            end
            iee_pkg::CMD_POP_B: begin
                if (r_ncnt == '0) begin
                    n_b   = ERR_VAL;
                    n_err = flag(r_err, iee_pkg::ST_UNDERFLOW);
                end else begin
                    n_b    = r_num_rd;
                    n_ncnt = r_ncnt - CW'(1);
                end
            end
            iee_pkg::CMD_POP_A, iee_pkg::CMD_RES_POP: begin
                if (r_ncnt == '0) begin
                    n_a   = ERR_VAL;
                    n_err = flag(r_err, iee_pkg::ST_UNDERFLOW);
                end else begin
                    n_a    = r_num_rd;
                    n_ncnt = r_ncnt - CW'(1);
                end
            end
            iee_pkg::CMD_DIV_ZERO: begin
                n_err = flag(r_err, iee_pkg::ST_DIV_ZERO);
            end
            iee_pkg::CMD_ALU_GO: begin
                alu_start = 1'b1;
                alu_op    = iee_pkg::t_alu_op'(r_opcode);
            end
            iee_pkg::CMD_EMIT: begin
                n_out_valid = 1'b1;
                n_out_data  = r_a;
                n_out_stat  = r_err;
                n_ncnt      = '0;
                n_opcnt     = '0;
                n_lit       = '0;
                n_fd        = '0;
                n_phase     = iee_pkg::PH_NONE;
                n_err       = iee_pkg::ST_OK;
            end
        endcase

        if (do_push) begin
            if (r_ncnt >= CW'(STACK_DEPTH)) begin
                n_err = flag(r_err, iee_pkg::ST_OVERFLOW);
            end else begin
                num_we = 1'b1;
                n_ncnt = r_ncnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lit       <= '0;
            r_fd        <= '0;
            r_phase     <= iee_pkg::PH_NONE;
            r_err       <= iee_pkg::ST_OK;
            r_ncnt      <= '0;
            r_opcnt     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_lit       <= n_lit;
            r_fd        <= n_fd;
            r_phase     <= n_phase;
            r_err       <= n_err;
            r_ncnt      <= n_ncnt;
            r_opcnt     <= n_opcnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char     <= n_char;
        r_a        <= n_a;
        r_b        <= n_b;
        r_opcode   <= n_opcode;
        r_out_data <= n_out_data;
        r_out_stat <= n_out_stat;
    end

    always_ff @(posedge i_clk) begin
        if (num_we) begin
            num_mem[AW'(r_ncnt)] <= num_wdata;
        end
        r_num_rd <= num_mem[num_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (op_we) begin
            op_mem[AW'(r_opcnt)] <= op_wdata;
        end
        r_op_rd <= op_mem[op_raddr];
    end

    always_comb begin
        o_stat.cls        = cls;
        o_stat.lit_active = r_phase != iee_pkg::PH_NONE;
        o_stat.op_empty   = r_opcnt == '0;
        o_stat.op_top     = r_op_rd;
        o_stat.opcode     = r_opcode;
        o_stat.b_zero     = r_b == '0;
        o_stat.alu_done   = alu_done;
        o_stat.out_free   = out_free;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_stat;

    a_ncnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ncnt <= CW'(STACK_DEPTH))
        else $error("number stack count beyond depth");

    a_opcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_opcnt <= CW'(STACK_DEPTH))
        else $error("operator stack count beyond depth");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cmd == iee_pkg::CMD_EMIT) |-> out_free)
        else $error("result written over a waiting beat");

    a_pop_arith: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.cmd == iee_pkg::CMD_ALU_GO) |-> (r_opcode != iee_pkg::OP_PAR))
        else $error("parenthesis sent to the arithmetic unit");

endmodule

`default_nettype wire

### rtl/iee_ctrl.sv
// Controller: state machine that sequences parsing, operator reduction and evaluation.
`default_nettype none

module iee_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_s_tvalid,
    output logic               o_s_tready,
    input  iee_pkg::t_dp_stat  i_stat,
    output iee_pkg::t_dp_cmd   o_cmd
);

    iee_pkg::t_state r_state, n_state;
    iee_pkg::t_paren r_pp, n_pp;

    logic is_lit_char;

    assign is_lit_char = i_stat.cls == iee_pkg::CH_DIGIT || i_stat.cls == iee_pkg::CH_POINT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iee_pkg::S_IDLE;
            r_pp    <= iee_pkg::PP_NONE;
        end else begin
            r_state <= n_state;
            r_pp    <= n_pp;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pp       = r_pp;
        o_cmd.cmd  = iee_pkg::CMD_NONE;
        o_cmd.neg  = 1'b0;
        o_s_tready = 1'b0;

        unique case (r_state)
            iee_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.cmd = iee_pkg::CMD_LOAD;
                    n_state   = iee_pkg::S_DECODE;
                end
            end
            iee_pkg::S_DECODE: begin
                unique case (r_pp)
                    iee_pkg::PP_NEG: begin
                        if (is_lit_char) begin
                            o_cmd.cmd = iee_pkg::CMD_LIT_CHAR;
                            n_state   = iee_pkg::S_IDLE;
                        end else if (i_stat.cls == iee_pkg::CH_CLOSE ||
                                     i_stat.cls == iee_pkg::CH_EQ) begin
                            n_state = iee_pkg::S_LIT_GO;
                        end else begin
                            n_state = iee_pkg::S_IDLE;
                        end
                    end
                    iee_pkg::PP_OPEN: begin
                        n_pp = iee_pkg::PP_NONE;
                        if (i_stat.cls == iee_pkg::CH_MINUS) begin
                            n_pp    = iee_pkg::PP_NEG;
                            n_state = iee_pkg::S_IDLE;
                        end else if (i_stat.cls == iee_pkg::CH_EQ) begin
                            n_state = iee_pkg::S_SETTLE;
                        end else begin
                            o_cmd.cmd = iee_pkg::CMD_OP_PUSH_PAR;
                            n_state   = iee_pkg::S_MAIN;
                        end
                    end
                    default: begin
                        n_state = iee_pkg::S_MAIN;
                    end
                endcase
            end
            iee_pkg::S_MAIN: begin
                if (is_lit_char) begin
                    o_cmd.cmd = iee_pkg::CMD_LIT_CHAR;
                    n_state   = iee_pkg::S_IDLE;
                end else if (i_stat.cls == iee_pkg::CH_OTHER) begin
                    n_state = iee_pkg::S_IDLE;
                end else if (i_stat.cls == iee_pkg::CH_OPEN) begin
                    if (i_stat.lit_active) begin
                        n_state = iee_pkg::S_LIT_GO;
                    end else begin
                        n_pp    = iee_pkg::PP_OPEN;
                        n_state = iee_pkg::S_IDLE;
                    end
                end else if (i_stat.lit_active) begin
                    n_state = iee_pkg::S_LIT_GO;
                end else begin
                    n_state = iee_pkg::S_SETTLE;
                end
            end
            iee_pkg::S_LIT_GO: begin
                o_cmd.cmd = iee_pkg::CMD_LIT_GO;
                n_state   = iee_pkg::S_LIT_WAIT;
            end
            iee_pkg::S_LIT_WAIT: begin
                if (i_stat.alu_done) begin
                    n_state = iee_pkg::S_LIT_PUSH;
                end
            end
            iee_pkg::S_LIT_PUSH: begin
                o_cmd.cmd = iee_pkg::CMD_PUSH_LIT;
                o_cmd.neg = r_pp == iee_pkg::PP_NEG;
                if (r_pp == iee_pkg::PP_NEG) begin
                    n_pp    = iee_pkg::PP_NONE;
                    n_state = (i_stat.cls == iee_pkg::CH_EQ) ? iee_pkg::S_SETTLE
                                                             : iee_pkg::S_IDLE;
                end else begin
                    n_state = iee_pkg::S_SETTLE;
                end
            end
            iee_pkg::S_SETTLE: begin
                n_state = iee_pkg::S_CHECK;
            end
            iee_pkg::S_CHECK: begin
                unique case (i_stat.cls)
                    iee_pkg::CH_PLUS, iee_pkg::CH_MINUS: begin
                        if (!i_stat.op_empty && i_stat.op_top != iee_pkg::OP_PAR) begin
                            n_state = iee_pkg::S_POP_OP;
                        end else begin
                            o_cmd.cmd = iee_pkg::CMD_OP_PUSH;
                            n_state   = iee_pkg::S_IDLE;
                        end
                    end
                    iee_pkg::CH_MUL, iee_pkg::CH_DIV: begin
                        if (!i_stat.op_empty && (i_stat.op_top == iee_pkg::OP_MUL ||
                                                 i_stat.op_top == iee_pkg::OP_DIV)) begin
                            n_state = iee_pkg::S_POP_OP;
                        end else begin
                            o_cmd.cmd = iee_pkg::CMD_OP_PUSH;
                            n_state   = iee_pkg::S_IDLE;
                        end
                    end
                    iee_pkg::CH_OPEN: begin
                        n_pp    = iee_pkg::PP_OPEN;
                        n_state = iee_pkg::S_IDLE;
                    end
                    iee_pkg::CH_CLOSE: begin
                        if (!i_stat.op_empty && i_stat.op_top != iee_pkg::OP_PAR) begin
                            n_state = iee_pkg::S_POP_OP;
                        end else begin
                            if (!i_stat.op_empty) begin
                                o_cmd.cmd = iee_pkg::CMD_OP_DROP;
                            end
                            n_state = iee_pkg::S_IDLE;
                        end
                    end
                    iee_pkg::CH_EQ: begin
                        if (!i_stat.op_empty) begin
                            n_state = iee_pkg::S_POP_OP;
                        end else begin
                            o_cmd.cmd = iee_pkg::CMD_RES_POP;
                            n_state   = iee_pkg::S_EMIT;
                        end
                    end
                    default: begin
                        n_state = iee_pkg::S_IDLE;
                    end
                endcase
            end
            iee_pkg::S_POP_OP: begin
                o_cmd.cmd = iee_pkg::CMD_OP_POP;
                n_state   = (i_stat.op_top == iee_pkg::OP_PAR) ? iee_pkg::S_SETTLE
                                                              : iee_pkg::S_POP_B;
            end
            iee_pkg::S_POP_B: begin
                o_cmd.cmd = iee_pkg::CMD_POP_B;
                n_state   = iee_pkg::S_POP_WAIT;
            end
            iee_pkg::S_POP_WAIT: begin
                n_state = iee_pkg::S_POP_A;
            end
            iee_pkg::S_POP_A: begin
                o_cmd.cmd = iee_pkg::CMD_POP_A;
                n_state   = iee_pkg::S_ALU_GO;
            end
            iee_pkg::S_ALU_GO: begin
                if (i_stat.opcode == iee_pkg::OP_DIV && i_stat.b_zero) begin
                    o_cmd.cmd = iee_pkg::CMD_DIV_ZERO;
                    n_state   = iee_pkg::S_SETTLE;
                end else begin
                    o_cmd.cmd = iee_pkg::CMD_ALU_GO;
                    n_state   = iee_pkg::S_ALU_WAIT;
                end
            end
            iee_pkg::S_ALU_WAIT: begin
                if (i_stat.alu_done) begin
                    n_state = iee_pkg::S_PUSH_RES;
                end
            end
            iee_pkg::S_PUSH_RES: begin
                o_cmd.cmd = iee_pkg::CMD_PUSH_RES;
                n_state   = iee_pkg::S_SETTLE;
            end
            iee_pkg::S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.cmd = iee_pkg::CMD_EMIT;
                    n_pp      = iee_pkg::PP_NONE;
                    n_state   = iee_pkg::S_IDLE;
                end
            end
        endcase
    end

endmodule

`default_nettype wire
